// ===== hdl/tlqs_pkg.sv =====
// Shared types and constants of the two-level queue scheduler.
package tlqs_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WB2,
        S_EMIT
    } t_state;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int APB_ADDR_W = 3;

    localparam logic REG_AGING   = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic [15:0] AGING_RESET   = 16'd50;
    localparam logic [15:0] QUANTUM_RESET = 16'd5;

    typedef struct packed {
        logic [15:0] aging_limit;
        logic [15:0] quantum;
    } t_cfg;

    typedef struct packed {
        logic       accepted;
        logic       ran_valid;
        logic [7:0] ran_id;
        logic       promoted_valid;
        logic [7:0] promoted_id;
        logic       retired_valid;
        logic [7:0] retired_id;
        logic       pending;
    } t_result;

endpackage

// ===== hdl/tlqs_ram.sv =====
// Queue entry memory with one write port and one registered read port.
module tlqs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlqs_cfg.sv =====
// Configuration registers behind the APB-style port.
module tlqs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlqs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output tlqs_pkg::t_cfg                  o_cfg
);

    import tlqs_pkg::*;

    logic [15:0] r_aging;
    logic [15:0] r_quantum;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging   <= AGING_RESET;
            r_quantum <= QUANTUM_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_AGING:   r_aging   <= pwdata[15:0];
                REG_QUANTUM: r_quantum <= pwdata[15:0];
                default:     r_aging   <= r_aging;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_AGING:   prdata = {16'b0, r_aging};
            REG_QUANTUM: prdata = {16'b0, r_quantum};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.aging_limit = r_aging;
    assign o_cfg.quantum     = r_quantum;

endmodule

// ===== hdl/tlqs_core.sv =====
// Scheduler control: queue pointers, tick execution and the result register.
module tlqs_core #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_WIDTH      = 8,
    parameter int RUNTIME_WIDTH = 16,
    parameter int TIME_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_process_id,
    input  logic [15:0]       i_runtime,
    input  logic              i_priority_req,
    input  tlqs_pkg::t_cfg    i_cfg,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tlqs_pkg::t_result o_result
);

    import tlqs_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int RW    = RUNTIME_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int FW    = ID_WIDTH + 2 * RW;
    localparam int BW    = FW + TW;
    localparam int IDX_W = (ID_WIDTH > 8) ? ID_WIDTH : 8;
    localparam int RTX_W = (RW > 16) ? RW : 16;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] f_id8(input logic [ID_WIDTH-1:0] id);
        logic [IDX_W-1:0] ext;
        ext   = IDX_W'(id);
        f_id8 = ext[7:0];
    endfunction

    t_state r_state, n_state;

    logic [AW-1:0] r_fg_head, r_fg_tail, r_bg_head, r_bg_tail;
    logic [CW-1:0] r_fg_count, r_bg_count;
    logic [TW-1:0] r_clock;
    logic          r_out_valid;
    t_result       r_out, r_res;
    logic [AW-1:0] r_wb_addr;
    logic [FW-1:0] r_wb_data;

    logic [FW-1:0] fg_rdata, fg_wdata;
    logic [BW-1:0] bg_rdata, bg_wdata;
    logic          fg_we, bg_we;
    logic [AW-1:0] fg_waddr, bg_waddr;

    logic [ID_WIDTH-1:0] fg_id, bg_id, s_id, add_id;
    logic [RW-1:0]       fg_rem, fg_base, bg_rem, bg_base, s_rem, s_base, add_rt;
    logic [RW-1:0]       new_rem, slice_diff;
    logic [TW-1:0]       bg_arr, waited, clock2;
    logic [IDX_W-1:0]    id_ext;
    logic [RTX_W-1:0]    rt_ext;

    logic          accept, out_free, add_full, add_ok;
    logic          promote, serve_fg, serve_bg, run, retire, rotate, s_fg_we, need_wb2;
    logic [CW-1:0] fg_cnt1, bg_cnt1, fg_cnt2, bg_cnt2;
    logic [AW-1:0] fg_tail1, bg_head1, fg_head2, fg_tail2, bg_head2, s_fg_addr;
    logic [FW-1:0] s_fg_data, pro_data;
    t_result       add_res, exec_res, res_now, out_src;
    logic          have_res, load_out, store_res;

    tlqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(FW)) u_fg_ram (
        .i_clk   (i_clk),
        .i_we    (fg_we),
        .i_waddr (fg_waddr),
        .i_wdata (fg_wdata),
        .i_raddr (r_fg_head),
        .o_rdata (fg_rdata)
    );

    tlqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(BW)) u_bg_ram (
        .i_clk   (i_clk),
        .i_we    (bg_we),
        .i_waddr (bg_waddr),
        .i_wdata (bg_wdata),
        .i_raddr (r_bg_head),
        .o_rdata (bg_rdata)
    );

    assign fg_id   = fg_rdata[FW-1 -: ID_WIDTH];
    assign fg_rem  = fg_rdata[2*RW-1 -: RW];
    assign fg_base = fg_rdata[RW-1:0];
    assign bg_id   = bg_rdata[BW-1 -: ID_WIDTH];
    assign bg_rem  = bg_rdata[TW+2*RW-1 -: RW];
    assign bg_base = bg_rdata[TW+RW-1 -: RW];
    assign bg_arr  = bg_rdata[TW-1:0];

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Add path.
    always_comb begin
        id_ext   = IDX_W'(i_process_id);
        rt_ext   = RTX_W'(i_runtime);
        add_id   = id_ext[ID_WIDTH-1:0];
        add_rt   = rt_ext[RW-1:0];
        add_full = i_priority_req ? (r_bg_count == FULL) : (r_fg_count == FULL);
        add_ok   = !add_full;

        add_res          = '0;
        add_res.accepted = add_ok;
        add_res.pending  = (r_fg_count != '0) || (r_bg_count != '0) || add_ok;
    end

    // Tick path: promotion, then service of the chosen head.
    always_comb begin
        waited  = r_clock - bg_arr;
        promote = (r_bg_count != '0) && (r_fg_count != FULL) &&
                  (waited >= TW'(i_cfg.aging_limit));

        fg_cnt1  = r_fg_count + CW'(promote);
        bg_cnt1  = r_bg_count - CW'(promote);
        fg_tail1 = promote ? f_next(r_fg_tail) : r_fg_tail;
        bg_head1 = promote ? f_next(r_bg_head) : r_bg_head;

        serve_fg = (fg_cnt1 != '0);
        serve_bg = !serve_fg && (bg_cnt1 != '0);

        if (serve_fg && (r_fg_count != '0)) begin
            s_id   = fg_id;
            s_rem  = fg_rem;
            s_base = fg_base;
        end else begin
            s_id   = bg_id;
            s_rem  = bg_rem;
            s_base = bg_base;
        end

        run        = (serve_fg || serve_bg) && (s_rem != '0);
        retire     = (serve_fg || serve_bg) && (s_rem == '0);
        new_rem    = s_rem - 1'b1;
        slice_diff = s_base - new_rem;
        rotate     = serve_fg && run && (new_rem != '0) &&
                     (RTX_W'(slice_diff) == RTX_W'(i_cfg.quantum));

        fg_head2 = (serve_fg && (rotate || retire)) ? f_next(r_fg_head) : r_fg_head;
        fg_tail2 = rotate ? f_next(fg_tail1) : fg_tail1;
        fg_cnt2  = fg_cnt1 - CW'(serve_fg && retire);
        bg_head2 = (serve_bg && retire) ? f_next(bg_head1) : bg_head1;
        bg_cnt2  = bg_cnt1 - CW'(serve_bg && retire);
        clock2   = r_clock + TW'(run);

        s_fg_we   = serve_fg && run;
        s_fg_addr = rotate ? fg_tail1 : r_fg_head;
        s_fg_data = {s_id, new_rem, rotate ? new_rem : s_base};
        pro_data  = {bg_id, bg_rem, bg_base};
        need_wb2  = promote && s_fg_we && (r_fg_count != '0);

        exec_res                = '0;
        exec_res.ran_valid      = run;
        exec_res.ran_id         = run ? f_id8(s_id) : 8'd0;
        exec_res.promoted_valid = promote;
        exec_res.promoted_id    = promote ? f_id8(bg_id) : 8'd0;
        exec_res.retired_valid  = retire;
        exec_res.retired_id     = retire ? f_id8(s_id) : 8'd0;
        exec_res.pending        = (fg_cnt2 != '0) || (bg_cnt2 != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_TICK) begin
                        n_state = S_EXEC;
                    end else if (!out_free) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EXEC: begin
                if (need_wb2) begin
                    n_state = S_WB2;
                end else begin
                    n_state = out_free ? S_IDLE : S_EMIT;
                end
            end
            S_WB2:   n_state = out_free ? S_IDLE : S_EMIT;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        have_res   = 1'b0;
        store_res  = 1'b0;
        res_now    = r_res;
        fg_we      = 1'b0;
        fg_waddr   = r_fg_tail;
        fg_wdata   = {add_id, add_rt, add_rt};
        bg_we      = 1'b0;
        bg_waddr   = r_bg_tail;
        bg_wdata   = {add_id, add_rt, add_rt, r_clock};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                res_now    = add_res;
                if (accept && (i_opcode == OP_ADD)) begin
                    have_res  = 1'b1;
                    store_res = !out_free;
                    fg_we     = add_ok && !i_priority_req;
                    bg_we     = add_ok && i_priority_req;
                end
            end
            S_EXEC: begin
                res_now   = exec_res;
                have_res  = !need_wb2;
                store_res = need_wb2 || !out_free;
                if (s_fg_we) begin
                    fg_we    = 1'b1;
                    fg_waddr = s_fg_addr;
                    fg_wdata = s_fg_data;
                end else if (promote) begin
                    fg_we    = 1'b1;
                    fg_waddr = r_fg_tail;
                    fg_wdata = pro_data;
                end
                bg_we    = serve_bg && run;
                bg_waddr = r_bg_head;
                bg_wdata = {s_id, new_rem, s_base, bg_arr};
            end
            S_WB2: begin
                have_res = 1'b1;
                fg_we    = 1'b1;
                fg_waddr = r_wb_addr;
                fg_wdata = r_wb_data;
            end
            S_EMIT: begin
                have_res = 1'b1;
            end
            default: begin
                have_res = 1'b0;
            end
        endcase
        load_out = have_res && out_free;
        out_src  = res_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fg_head   <= '0;
            r_fg_tail   <= '0;
            r_fg_count  <= '0;
            r_bg_head   <= '0;
            r_bg_tail   <= '0;
            r_bg_count  <= '0;
            r_clock     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && accept && i_opcode == OP_ADD && add_ok) begin
                if (i_priority_req) begin
                    r_bg_tail  <= f_next(r_bg_tail);
                    r_bg_count <= r_bg_count + 1'b1;
                end else begin
                    r_fg_tail  <= f_next(r_fg_tail);
                    r_fg_count <= r_fg_count + 1'b1;
                end
            end
            if (r_state == S_EXEC) begin
                r_fg_head  <= fg_head2;
                r_fg_tail  <= fg_tail2;
                r_fg_count <= fg_cnt2;
                r_bg_head  <= bg_head2;
                r_bg_count <= bg_cnt2;
                r_clock    <= clock2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= out_src;
        end
        if (store_res) begin
            r_res <= res_now;
        end
        if (r_state == S_EXEC) begin
            r_wb_addr <= r_fg_tail;
            r_wb_data <= pro_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fg_count <= FULL) && (r_bg_count <= FULL))
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fg_count == '0) |-> (r_fg_head == r_fg_tail))
        else $error("empty foreground queue with head and tail apart");

    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state != S_EXEC))
        else $error("tick executed twice");

    a_promote_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && promote) |-> (r_bg_count != '0 && r_fg_count < FULL))
        else $error("promotion without room or source");

    a_ran_or_retired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.ran_valid && r_out.retired_valid))
        else $error("word reports both a run and a retirement");
`endif

endmodule

// ===== hdl/two_level_queue_scheduler_unit.sv =====
// Top level of the two-level queue scheduler with aging.
//
// Input words arrive on i_in_valid/o_in_ready: an add (opcode add) queues a
// process id and its runtime in the foreground or background queue, and a
// tick promotes an aged background head and then serves one queue head.
// Every input word yields exactly one result word on o_out_valid/i_out_ready.
// An add is accepted in the idle state and its result is registered at the
// accepting edge. A tick reads both queue heads from memory at acceptance and
// executes in the next cycle; a tick that promotes into a non-empty
// foreground queue and also runs the foreground head needs the extra S_WB2
// state for the second write to the single foreground memory port.
// The block works on one word at a time and accepts the next word while the
// previous result still waits in the output register. If the receiver
// stalls and the output register is full, the finished result is held and
// no new word is accepted until the output register drains.
// After reset both queues are empty, the run clock is all ones and the
// aging limit and quantum registers hold 50 and 5. Queue memories are not
// cleared; only occupied entries are ever read.
module two_level_queue_scheduler_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_WIDTH      = 8,
    parameter int RUNTIME_WIDTH = 16,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlqs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [7:0]                      i_process_id,
    input  logic [15:0]                     i_runtime,
    input  logic                            i_priority_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic                            o_ran_valid,
    output logic [7:0]                      o_ran_id,
    output logic                            o_promoted_valid,
    output logic [7:0]                      o_promoted_id,
    output logic                            o_retired_valid,
    output logic [7:0]                      o_retired_id,
    output logic                            o_pending
);

    import tlqs_pkg::*;

    t_cfg    cfg;
    t_result result;

    tlqs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlqs_core #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_WIDTH      (ID_WIDTH),
        .RUNTIME_WIDTH (RUNTIME_WIDTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_process_id   (i_process_id),
        .i_runtime      (i_runtime),
        .i_priority_req (i_priority_req),
        .i_cfg          (cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (result)
    );

    assign o_accepted       = result.accepted;
    assign o_ran_valid      = result.ran_valid;
    assign o_ran_id         = result.ran_id;
    assign o_promoted_valid = result.promoted_valid;
    assign o_promoted_id    = result.promoted_id;
    assign o_retired_valid  = result.retired_valid;
    assign o_retired_id     = result.retired_id;
    assign o_pending        = result.pending;

endmodule
